>>> rtl/core/nprt_pkg.sv
// ----------------------------------------------------------------------------
// nprt_pkg
// Types and constants shared by the nearest point ratio test block and its
// port checker.
// ----------------------------------------------------------------------------
package nprt_pkg;

	localparam int COORD_BITS  = 24;
	localparam int LABEL_BITS  = 24;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * COORD_BITS + 1;
	localparam int DIST_BITS   = 2 * COORD_BITS + 2;
	localparam int RATIO_SHIFT = 2;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_X = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_Y = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_QUERY_Z = CFG_IDX_BITS'(2);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [SQ_BITS-1:0]           sq_t;
	typedef logic [LABEL_BITS-1:0]        label_t;
	typedef logic [DIST_BITS-1:0]         dist_t;

	typedef enum logic [1:0] {
		STATUS_UNIQUE    = 2'd0,
		STATUS_AMBIGUOUS = 2'd1,
		STATUS_EMPTY     = 2'd2
	} status_t;

	typedef struct packed {
		coord_t cand_x;
		coord_t cand_y;
		coord_t cand_z;
		label_t cand_label;
		logic   last_cand;
	} cand_t;

	typedef struct packed {
		status_t status;
		label_t  best_label;
		dist_t   best_dist_sq;
		label_t  runner_label;
		dist_t   runner_dist_sq;
		logic    runner_present;
	} res_t;

endpackage

>>> rtl/core/nearest_point_ratio_test.sv
// ----------------------------------------------------------------------------
// nearest_point_ratio_test
// Streams candidate points against a configured query point, keeps the
// nearest and next-nearest by squared distance and reports a ratio test
// result on the word marked last.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  cand     cand_valid/cand_ready   cand (nprt_pkg::cand_t)
//  res      res_valid/res_ready     res (nprt_pkg::res_t)
//  cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  one candidate word per cycle unless a stalled result holds the pipeline
//  stages: input register, three squares, sum, running minimum and result register
//  the running minimum update is combinational, so there is no per-item stall
//  reset clears the query registers, the search state and all valid bits
//  a stalled result freezes the whole pipeline; cfg_ready is always high
//
module nearest_point_ratio_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cand_valid,
	output logic                               cand_ready,
	input  nprt_pkg::cand_t                    cand,
	output logic                               res_valid,
	input  logic                               res_ready,
	output nprt_pkg::res_t                     res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nprt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  nprt_pkg::coord_t                   cfg_data
);

	nprt_pkg::coord_t query_x_q, query_y_q, query_z_q;

	logic            vld_s1;
	nprt_pkg::cand_t cand_s1;

	logic             vld_s2;
	nprt_pkg::sq_t    sqx_s2, sqy_s2, sqz_s2;
	nprt_pkg::label_t label_s2;
	logic             last_s2;

	logic             vld_s3;
	nprt_pkg::dist_t  dist_s3;
	nprt_pkg::label_t label_s3;
	logic             last_s3;

	nprt_pkg::dist_t  best_dist_q, second_dist_q;
	nprt_pkg::label_t best_id_q, second_id_q;
	logic             best_seen_q, second_seen_q;

	logic           res_valid_q;
	nprt_pkg::res_t res_q;

	logic advance;

	nprt_pkg::diff_t dx, dy, dz;
	logic signed [2*nprt_pkg::DIFF_BITS-1:0] px, py, pz;

	logic             take_best, take_second;
	nprt_pkg::dist_t  nb_dist, ns_dist;
	nprt_pkg::label_t nb_id, ns_id;
	logic             nb_seen, ns_seen;
	logic             ambiguous;
	nprt_pkg::res_t   res_d;

	assign advance    = !res_valid_q || res_ready;
	assign cand_ready = advance;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// query registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			query_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				nprt_pkg::REG_QUERY_X: query_x_q <= cfg_data;
				nprt_pkg::REG_QUERY_Y: query_y_q <= cfg_data;
				nprt_pkg::REG_QUERY_Z: query_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squares of the coordinate differences
	always_comb begin
		dx = nprt_pkg::diff_t'(query_x_q) - nprt_pkg::diff_t'(cand_s1.cand_x);
		dy = nprt_pkg::diff_t'(query_y_q) - nprt_pkg::diff_t'(cand_s1.cand_y);
		dz = nprt_pkg::diff_t'(query_z_q) - nprt_pkg::diff_t'(cand_s1.cand_z);
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= cand_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cand_s1  <= cand;
			sqx_s2   <= px[nprt_pkg::SQ_BITS-1:0];
			sqy_s2   <= py[nprt_pkg::SQ_BITS-1:0];
			sqz_s2   <= pz[nprt_pkg::SQ_BITS-1:0];
			label_s2 <= cand_s1.cand_label;
			last_s2  <= cand_s1.last_cand;
			dist_s3  <= nprt_pkg::dist_t'(sqx_s2) + nprt_pkg::dist_t'(sqy_s2)
				+ nprt_pkg::dist_t'(sqz_s2);
			label_s3 <= label_s2;
			last_s3  <= last_s2;
		end
	end

	// running minimum and ratio test
	always_comb begin
		take_best   = !best_seen_q || (dist_s3 < best_dist_q);
		take_second = !second_seen_q || (dist_s3 < second_dist_q);
		nb_dist = best_dist_q;
		nb_id   = best_id_q;
		nb_seen = best_seen_q;
		ns_dist = second_dist_q;
		ns_id   = second_id_q;
		ns_seen = second_seen_q;
		if (take_best) begin
			ns_dist = best_dist_q;
			ns_id   = best_id_q;
			ns_seen = best_seen_q;
			nb_dist = dist_s3;
			nb_id   = label_s3;
			nb_seen = 1'b1;
		end else if (take_second) begin
			ns_dist = dist_s3;
			ns_id   = label_s3;
			ns_seen = 1'b1;
		end
		ambiguous = ns_seen &&
			({{nprt_pkg::RATIO_SHIFT{1'b0}}, ns_dist} <
			 {nb_dist, {nprt_pkg::RATIO_SHIFT{1'b0}}});
		res_d = '0;
		if (!nb_seen) begin
			res_d.status = nprt_pkg::STATUS_EMPTY;
		end else begin
			res_d.status         = ambiguous ? nprt_pkg::STATUS_AMBIGUOUS
			                                 : nprt_pkg::STATUS_UNIQUE;
			res_d.best_label     = nb_id;
			res_d.best_dist_sq   = nb_dist;
			res_d.runner_label   = ns_seen ? ns_id : '0;
			res_d.runner_dist_sq = ns_seen ? ns_dist : '0;
			res_d.runner_present = ns_seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q   <= '1;
			best_id_q     <= '0;
			best_seen_q   <= 1'b0;
			second_dist_q <= '1;
			second_id_q   <= '0;
			second_seen_q <= 1'b0;
		end else if (advance && vld_s3) begin
			if (last_s3) begin
				best_dist_q   <= '1;
				best_id_q     <= '0;
				best_seen_q   <= 1'b0;
				second_dist_q <= '1;
				second_id_q   <= '0;
				second_seen_q <= 1'b0;
			end else begin
				best_dist_q   <= nb_dist;
				best_id_q     <= nb_id;
				best_seen_q   <= nb_seen;
				second_dist_q <= ns_dist;
				second_id_q   <= ns_id;
				second_seen_q <= ns_seen;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= vld_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s3 && last_s3) begin
			res_q <= res_d;
		end
	end

endmodule

>>> rtl/core/nprt_checker.sv
// ----------------------------------------------------------------------------
// nprt_checker
// Port level checks on the result channel of the nearest point ratio test.
// ----------------------------------------------------------------------------
module nprt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input nprt_pkg::res_t res
);

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// every search has at least its last word as a candidate
	a_never_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status == nprt_pkg::STATUS_UNIQUE ||
			res.status == nprt_pkg::STATUS_AMBIGUOUS)
		else $error("empty or undefined status");

	a_lone_unique: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.runner_present |->
			res.status == nprt_pkg::STATUS_UNIQUE && res.runner_label == '0 &&
			res.runner_dist_sq == '0)
		else $error("lone candidate result malformed");

	a_runner_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.runner_present |-> res.runner_dist_sq >= res.best_dist_sq)
		else $error("runner nearer than best");

	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.runner_present |->
			(res.status == nprt_pkg::STATUS_AMBIGUOUS) ==
			({{nprt_pkg::RATIO_SHIFT{1'b0}}, res.runner_dist_sq} <
			 {res.best_dist_sq, {nprt_pkg::RATIO_SHIFT{1'b0}}}))
		else $error("ratio test status mismatch");

endmodule

bind nearest_point_ratio_test nprt_checker u_nprt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives candidate words and query register writes into the nearest point
// ratio test block, with random gaps on the candidate side and random stalls
// on the result side. Every result word is checked field by field against its
// typed expectation or an in-line nearest / next-nearest ratio test model.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ITEMS        = 1300;
	localparam int DRAIN_CYCLES = 10;
	localparam int HANG_LIMIT   = 4000;

	localparam nprt_pkg::coord_t C_MIN = 24'sh800000;
	localparam nprt_pkg::coord_t C_MAX = 24'sh7FFFFF;

	localparam logic [nprt_pkg::CFG_IDX_BITS-1:0] REG_UNUSED =
		(nprt_pkg::CFG_IDX_BITS)'(3);

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PT,
		ROW_PT_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t                          kind;
		logic [nprt_pkg::CFG_IDX_BITS-1:0]  idx;
		nprt_pkg::coord_t                   data;
		nprt_pkg::cand_t                    pt;
		nprt_pkg::res_t                     want;
	} row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cand_valid;
	logic                               cand_ready;
	nprt_pkg::cand_t                    cand;
	logic                               res_valid;
	logic                               res_ready;
	nprt_pkg::res_t                     res;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [nprt_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	nprt_pkg::coord_t                   cfg_data;

	// typed expectation travels with the word that closes the search
	logic           typed_en;
	nprt_pkg::res_t typed_res;

	// model copy of the query registers and the search slots
	nprt_pkg::coord_t q_x = '0;
	nprt_pkg::coord_t q_y = '0;
	nprt_pkg::coord_t q_z = '0;
	logic [63:0]      near_dist = '1;
	nprt_pkg::label_t near_lab  = '0;
	logic             near_seen = 1'b0;
	logic [63:0]      alt_dist  = '1;
	nprt_pkg::label_t alt_lab   = '0;
	logic             alt_seen  = 1'b0;

	nprt_pkg::res_t pending_res[$];
	row_t           dir_rows[$];

	int err_count   = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	int stall_left  = 0;

	nearest_point_ratio_test DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand       (cand),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] dist_to_query(input nprt_pkg::cand_t c);
		nprt_pkg::coord_t cx;
		nprt_pkg::coord_t cy;
		nprt_pkg::coord_t cz;
		longint dx;
		longint dy;
		longint dz;
		cx = c.cand_x;
		cy = c.cand_y;
		cz = c.cand_z;
		dx = longint'(cx) - longint'(q_x);
		dy = longint'(cy) - longint'(q_y);
		dz = longint'(cz) - longint'(q_z);
		return 64'(dx * dx + dy * dy + dz * dz);
	endfunction

	task automatic track_candidate(input nprt_pkg::cand_t c, output logic emit,
			output nprt_pkg::res_t r);
		logic [63:0] d;
		d = dist_to_query(c);
		emit = 1'b0;
		r = '0;
		if (!near_seen || d < near_dist) begin
			alt_dist  = near_dist;
			alt_lab   = near_lab;
			alt_seen  = near_seen;
			near_dist = d;
			near_lab  = c.cand_label;
			near_seen = 1'b1;
		end else if (!alt_seen || d < alt_dist) begin
			alt_dist = d;
			alt_lab  = c.cand_label;
			alt_seen = 1'b1;
		end
		if (c.last_cand) begin
			emit = 1'b1;
			if (!near_seen) begin
				r.status = nprt_pkg::STATUS_EMPTY;
			end else begin
				if (alt_seen && alt_dist < (near_dist << 2))
					r.status = nprt_pkg::STATUS_AMBIGUOUS;
				else
					r.status = nprt_pkg::STATUS_UNIQUE;
				r.best_label   = near_lab;
				r.best_dist_sq = nprt_pkg::dist_t'(near_dist);
				if (alt_seen) begin
					r.runner_label   = alt_lab;
					r.runner_dist_sq = nprt_pkg::dist_t'(alt_dist);
					r.runner_present = 1'b1;
				end
			end
			near_dist = '1;
			near_lab  = '0;
			near_seen = 1'b0;
			alt_dist  = '1;
			alt_lab   = '0;
			alt_seen  = 1'b0;
		end
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		logic emit;
		nprt_pkg::res_t pred;
		nprt_pkg::res_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					nprt_pkg::REG_QUERY_X: q_x = cfg_data;
					nprt_pkg::REG_QUERY_Y: q_y = cfg_data;
					nprt_pkg::REG_QUERY_Z: q_z = cfg_data;
					default: ;
				endcase
			end
			if (cand_valid && cand_ready) begin
				moved = 1'b1;
				track_candidate(cand, emit, pred);
				if (emit)
					pending_res.push_back(typed_en ? typed_res : pred);
			end
			if (res_valid && res_ready) begin
				moved = 1'b1;
				if (pending_res.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result word, expected none actual %h", $time, res);
				end else begin
					want = pending_res.pop_front();
					check_field("status", 64'(want.status), 64'(res.status));
					check_field("best_label", 64'(want.best_label), 64'(res.best_label));
					check_field("best_dist_sq", 64'(want.best_dist_sq),
						64'(res.best_dist_sq));
					check_field("runner_label", 64'(want.runner_label),
						64'(res.runner_label));
					check_field("runner_dist_sq", 64'(want.runner_dist_sq),
						64'(res.runner_dist_sq));
					check_field("runner_present", 64'(want.runner_present),
						64'(res.runner_present));
				end
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// result side back-pressure in stretches
	initial begin : result_sink
		int r;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					res_ready  = 1'b1;
					stall_left = $urandom_range(100, 300);
				end else if (r < 60) begin
					res_ready  = 1'b1;
					stall_left = $urandom_range(1, 30);
				end else if (r < 87) begin
					res_ready  = 1'b0;
					stall_left = $urandom_range(1, 3);
				end else if (r < 97) begin
					res_ready  = 1'b0;
					stall_left = $urandom_range(4, 12);
				end else begin
					res_ready  = 1'b0;
					stall_left = $urandom_range(30, 60);
				end
			end
			stall_left--;
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(50, 150);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic nprt_pkg::cand_t mk_pt(input int x, input int y, input int z,
			input nprt_pkg::label_t lab, input logic last);
		nprt_pkg::cand_t p;
		p.cand_x     = nprt_pkg::coord_t'(x);
		p.cand_y     = nprt_pkg::coord_t'(y);
		p.cand_z     = nprt_pkg::coord_t'(z);
		p.cand_label = lab;
		p.last_cand  = last;
		return p;
	endfunction

	function automatic nprt_pkg::coord_t jitter(input nprt_pkg::coord_t base,
			input int span);
		int off;
		off = int'($urandom_range(0, 2 * span)) - span;
		return nprt_pkg::coord_t'(int'(base) + off);
	endfunction

	function automatic nprt_pkg::coord_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic nprt_pkg::cand_t gen_point(input nprt_pkg::cand_t prev);
		nprt_pkg::cand_t p;
		int r;
		int span;
		p = prev;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			span = (r < 30) ? 4 : ((r < 50) ? 300 : 100000);
			p.cand_x = jitter(q_x, span);
			p.cand_y = jitter(q_y, span);
			p.cand_z = jitter(q_z, span);
		end else if (r < 80) begin
			p.cand_x = nprt_pkg::coord_t'($urandom);
			p.cand_y = nprt_pkg::coord_t'($urandom);
			p.cand_z = nprt_pkg::coord_t'($urandom);
		end else if (r < 88) begin
			p.cand_x = pick_extreme();
			p.cand_y = pick_extreme();
			p.cand_z = pick_extreme();
		end
		r = $urandom_range(0, 99);
		if (r < 8)
			p.cand_label = '0;
		else if (r < 16)
			p.cand_label = '1;
		else
			p.cand_label = nprt_pkg::label_t'($urandom);
		p.last_cand = 1'b0;
		return p;
	endfunction

	task automatic put_cand(input nprt_pkg::cand_t c, input logic tv,
			input nprt_pkg::res_t tr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cand_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cand_valid = 1'b1;
		cand       = c;
		typed_en   = tv;
		typed_res  = tr;
		@(posedge clk);
		while (!cand_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cand_valid = 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [nprt_pkg::CFG_IDX_BITS-1:0] idx,
			input nprt_pkg::coord_t val);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic tab_cfg(input logic [nprt_pkg::CFG_IDX_BITS-1:0] idx,
			input nprt_pkg::coord_t val);
		row_t row;
		row      = '0;
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.data = val;
		dir_rows.push_back(row);
	endtask

	task automatic tab_pt(input int x, input int y, input int z,
			input nprt_pkg::label_t lab, input logic last);
		row_t row;
		row      = '0;
		row.kind = ROW_PT;
		row.pt   = mk_pt(x, y, z, lab, last);
		dir_rows.push_back(row);
	endtask

	task automatic tab_chk(input int x, input int y, input int z,
			input nprt_pkg::label_t lab, input nprt_pkg::status_t st,
			input nprt_pkg::label_t bl, input logic [63:0] bd,
			input nprt_pkg::label_t rl, input logic [63:0] rd, input logic rp);
		row_t row;
		row      = '0;
		row.kind = ROW_PT_TYPED;
		row.pt   = mk_pt(x, y, z, lab, 1'b1);
		row.want.status         = st;
		row.want.best_label     = bl;
		row.want.best_dist_sq   = nprt_pkg::dist_t'(bd);
		row.want.runner_label   = rl;
		row.want.runner_dist_sq = nprt_pkg::dist_t'(rd);
		row.want.runner_present = rp;
		dir_rows.push_back(row);
	endtask

	initial begin : stimulus
		int sent;
		int phase;
		int phase_len;
		int n;
		int slen;
		int r;
		nprt_pkg::cand_t prev;
		nprt_pkg::cand_t pt;
		arst_n     = 1'b0;
		cand_valid = 1'b0;
		cand       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		typed_en   = 1'b0;
		typed_res  = '0;

		tab_chk(0, 0, 0, 24'h000000, nprt_pkg::STATUS_UNIQUE, 24'h000000, 64'd0,
			24'd0, 64'd0, 1'b0);
		tab_chk(C_MIN, C_MIN, C_MIN, 24'hFFFFFF,
			nprt_pkg::STATUS_UNIQUE, 24'hFFFFFF, 64'd211106232532992, 24'd0, 64'd0, 1'b0);
		tab_chk(C_MAX, C_MAX, C_MAX, 24'h000001,
			nprt_pkg::STATUS_UNIQUE, 24'h000001, 64'd211106182201347, 24'd0, 64'd0, 1'b0);
		// runner at exactly four times the best
		tab_pt(1, 0, 0, 24'd10, 1'b0);
		tab_chk(2, 0, 0, 24'd20, nprt_pkg::STATUS_UNIQUE, 24'd10, 64'd1, 24'd20, 64'd4,
			1'b1);
		tab_pt(1, 0, 0, 24'd11, 1'b0);
		tab_chk(1, 1, 1, 24'd12, nprt_pkg::STATUS_AMBIGUOUS, 24'd11, 64'd1, 24'd12,
			64'd3, 1'b1);
		// tie with the best goes to the runner slot
		tab_pt(0, 0, 3, 24'd30, 1'b0);
		tab_chk(3, 0, 0, 24'd31, nprt_pkg::STATUS_AMBIGUOUS, 24'd30, 64'd9, 24'd31,
			64'd9, 1'b1);
		// tie with the runner keeps the earlier one
		tab_pt(1, 0, 0, 24'd40, 1'b0);
		tab_pt(0, 2, 0, 24'd41, 1'b0);
		tab_chk(0, 0, 2, 24'd42, nprt_pkg::STATUS_UNIQUE, 24'd40, 64'd1, 24'd41, 64'd4,
			1'b1);
		tab_pt(0, 0, 5, 24'd50, 1'b0);
		tab_chk(0, 0, 1, 24'd51, nprt_pkg::STATUS_UNIQUE, 24'd51, 64'd1, 24'd50, 64'd25,
			1'b1);
		tab_pt(0, 0, 1, 24'd60, 1'b0);
		tab_pt(0, 0, 9, 24'd61, 1'b0);
		tab_pt(0, 0, 3, 24'd62, 1'b1);
		tab_cfg(nprt_pkg::REG_QUERY_X, C_MAX);
		tab_cfg(nprt_pkg::REG_QUERY_Y, C_MAX);
		tab_cfg(nprt_pkg::REG_QUERY_Z, C_MAX);
		tab_chk(C_MIN, C_MIN, C_MIN, 24'h5A5A5A,
			nprt_pkg::STATUS_UNIQUE, 24'h5A5A5A, 64'd844424829468675, 24'd0, 64'd0, 1'b0);
		tab_cfg(REG_UNUSED, 24'sh123456);
		tab_chk(C_MAX, C_MAX, C_MAX, 24'hA5A5A5, nprt_pkg::STATUS_UNIQUE, 24'hA5A5A5,
			64'd0, 24'd0, 64'd0, 1'b0);
		tab_cfg(nprt_pkg::REG_QUERY_X, C_MIN);
		tab_cfg(nprt_pkg::REG_QUERY_Y, C_MIN);
		tab_cfg(nprt_pkg::REG_QUERY_Z, C_MIN);
		tab_pt(C_MAX, C_MAX, C_MAX, 24'h000001, 1'b0);
		tab_pt(C_MIN, C_MIN, C_MIN, 24'h800000, 1'b0);
		tab_pt(C_MIN + 1, C_MIN, C_MIN, 24'h000003, 1'b1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_idle();

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG:      write_reg(dir_rows[i].idx, dir_rows[i].data);
				ROW_PT:       put_cand(dir_rows[i].pt, 1'b0, '0);
				ROW_PT_TYPED: put_cand(dir_rows[i].pt, 1'b1, dir_rows[i].want);
				default: ;
			endcase
		end

		sent  = 0;
		phase = 0;
		while (sent < ITEMS) begin
			case (phase % 6)
				0: begin
					write_reg(nprt_pkg::REG_QUERY_X, '0);
					write_reg(nprt_pkg::REG_QUERY_Y, '0);
					write_reg(nprt_pkg::REG_QUERY_Z, '0);
				end
				1: begin
					write_reg(nprt_pkg::REG_QUERY_X, C_MAX);
					write_reg(nprt_pkg::REG_QUERY_Y, C_MAX);
					write_reg(nprt_pkg::REG_QUERY_Z, C_MAX);
				end
				2: begin
					write_reg(nprt_pkg::REG_QUERY_X, C_MIN);
					write_reg(nprt_pkg::REG_QUERY_Y, C_MIN);
					write_reg(nprt_pkg::REG_QUERY_Z, C_MIN);
				end
				3: begin
					write_reg(nprt_pkg::REG_QUERY_X, C_MAX);
					write_reg(nprt_pkg::REG_QUERY_Y, C_MIN);
					write_reg(nprt_pkg::REG_QUERY_Z, '0);
					write_reg(REG_UNUSED, nprt_pkg::coord_t'($urandom));
				end
				default: begin
					write_reg(nprt_pkg::REG_QUERY_X, nprt_pkg::coord_t'($urandom));
					write_reg(nprt_pkg::REG_QUERY_Y, nprt_pkg::coord_t'($urandom));
					write_reg(nprt_pkg::REG_QUERY_Z, nprt_pkg::coord_t'($urandom));
				end
			endcase
			phase_len = $urandom_range(40, 160);
			n = 0;
			prev = mk_pt(int'(q_x), int'(q_y), int'(q_z), '0, 1'b0);
			while (n < phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					slen = $urandom_range(1, 4);
				else if (r < 90)
					slen = $urandom_range(5, 16);
				else
					slen = $urandom_range(17, 48);
				for (int k = 0; k < slen; k++) begin
					pt = gen_point(prev);
					pt.last_cand = (k == slen - 1);
					put_cand(pt, 1'b0, '0);
					prev = pt;
				end
				n += slen;
				if ($urandom_range(0, 19) == 0)
					wait_idle();
			end
			sent += n;
			phase++;
		end

		wait_idle();
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
